>>> src/wmu_pkg.sv
`timescale 1ns / 1ps
// wmu_pkg: shared constants and types for the weighted mean unit.
// No dependencies; imported by every module of the block.
package wmu_pkg;

    localparam int WMU_FRAC_BITS = 8;
    localparam int WMU_MAX_ITEMS = 1024;
    localparam int WMU_DATA_W    = 16;
    // Product of a 16-bit value and a 16-bit weight.
    localparam int WMU_PROD_W    = 2 * WMU_DATA_W;

    // Weight used when weighting is off: one in fixed point.
    localparam logic signed [WMU_DATA_W:0] WMU_ONE =
        (WMU_DATA_W + 1)'(1 << WMU_FRAC_BITS);

    typedef struct packed {
        logic signed [WMU_DATA_W-1:0] mean;
        logic                         zero_weight_sum;
    } t_wmu_result;

endpackage

>>> src/weighted_mean_unit.sv
`timescale 1ns / 1ps
// weighted_mean_unit: weighted mean of signed Q8.8 words. Words stream in at one per
// cycle while busy is low; on a word marked last the totals go to a bit-serial divider.
// The strobe o_done follows the divider's result, which skips the divide loop when the
// weight sum is zero; busy stays high until the strobe cycle.
// The receiver cannot stall: o_done is high for a single cycle.
// Reset (synchronous, active low) clears both sums, the sequencer and use_weights.
module weighted_mean_unit import wmu_pkg::*; #(
    parameter int MAX_ITEMS = WMU_MAX_ITEMS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input words
    input  logic                         start,
    output logic                         busy,
    input  logic signed [WMU_DATA_W-1:0] i_value,
    input  logic signed [WMU_DATA_W-1:0] i_weight,
    input  logic                         i_last,
    // Configuration: use_weights
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_data,
    output logic                         o_cfg_ready,
    // Results
    output logic                         o_done,
    output logic signed [WMU_DATA_W-1:0] o_mean,
    output logic                         o_zero_weight_sum
);

    // Sums stay exact for MAX_ITEMS words: product width plus count bits.
    localparam int CNT_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 0;
    localparam int PSUM_W   = WMU_PROD_W + CNT_BITS;
    localparam int WSUM_W   = WMU_DATA_W + CNT_BITS;

    logic              r_use_weights;
    logic              accept;
    logic              go;
    logic [PSUM_W-1:0] psum;
    logic [WSUM_W-1:0] wsum;
    logic              div_busy;
    t_wmu_result       result;

    // Hold off new words from the last word until the divider strobes.
    assign busy        = go || div_busy;
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_weights <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_use_weights <= i_cfg_data;
        end
    end

    // Accumulate one word per cycle while busy is low; hand off totals on the last word.
    wmu_accum #(
        .PSUM_W (PSUM_W),
        .WSUM_W (WSUM_W)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_use_weights (r_use_weights),
        .i_value       (i_value),
        .i_weight      (i_weight),
        .i_last        (i_last),
        .o_go          (go),
        .o_psum        (psum),
        .o_wsum        (wsum)
    );

    // Divide product sum by weight sum, truncate toward zero, saturate to 16 bits.
    wmu_div #(
        .PSUM_W (PSUM_W),
        .WSUM_W (WSUM_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_num    (psum),
        .i_den    (wsum),
        .o_busy   (div_busy),
        .o_done   (o_done),
        .o_result (result)
    );

    assign o_mean            = result.mean;
    assign o_zero_weight_sum = result.zero_weight_sum;

endmodule

>>> src/wmu_accum.sv
`timescale 1ns / 1ps
// wmu_accum: running sums of value*weight and of weight, one word per cycle on i_accept.
// Depends on wmu_pkg; hands final totals to wmu_div on the last word.
module wmu_accum import wmu_pkg::*; #(
    parameter int PSUM_W = 42,
    parameter int WSUM_W = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_use_weights,
    input  logic signed [WMU_DATA_W-1:0] i_value,
    input  logic signed [WMU_DATA_W-1:0] i_weight,
    input  logic                         i_last,
    output logic                         o_go,
    output logic        [PSUM_W-1:0]     o_psum,
    output logic        [WSUM_W-1:0]     o_wsum
);

    logic        [PSUM_W-1:0]     r_psum;
    logic        [WSUM_W-1:0]     r_wsum;
    logic                         r_go;
    logic        [PSUM_W-1:0]     r_psum_out;
    logic        [WSUM_W-1:0]     r_wsum_out;

    logic signed [WMU_DATA_W:0]   w;
    logic signed [WMU_PROD_W:0]   p;
    logic        [PSUM_W-1:0]     n_psum;
    logic        [WSUM_W-1:0]     n_wsum;

    always_comb begin
        w      = i_use_weights ? (WMU_DATA_W + 1)'(i_weight) : WMU_ONE;
        p      = i_value * w;
        n_psum = r_psum + PSUM_W'(p);
        n_wsum = r_wsum + WSUM_W'(w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
            r_wsum <= '0;
            r_go   <= 1'b0;
        end else begin
            r_go <= i_accept && i_last;
            if (i_accept) begin
                // Clear after the last word; its totals move to the divider.
                r_psum <= i_last ? '0 : n_psum;
                r_wsum <= i_last ? '0 : n_wsum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_last) begin
            r_psum_out <= n_psum;
            r_wsum_out <= n_wsum;
        end
    end

    assign o_go   = r_go;
    assign o_psum = r_psum_out;
    assign o_wsum = r_wsum_out;

endmodule

>>> src/wmu_div.sv
`timescale 1ns / 1ps
// wmu_div: signed restoring divider, one quotient bit per cycle, with saturation.
// Depends on wmu_pkg for the result type.
module wmu_div import wmu_pkg::*; #(
    parameter int PSUM_W = 42,
    parameter int WSUM_W = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [PSUM_W-1:0] i_num,
    input  logic [WSUM_W-1:0] i_den,
    output logic              o_busy,
    output logic              o_done,
    output t_wmu_result       o_result
);

    localparam int CNT_W = (PSUM_W > 1) ? $clog2(PSUM_W) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PSUM_W-1:0]   r_num;
    logic [WSUM_W-1:0]   r_den;
    logic [WSUM_W-1:0]   r_rem;
    logic                r_neg;
    logic                r_zero;
    t_wmu_result         r_result;

    logic [WSUM_W:0]     shifted;
    logic [WSUM_W:0]     diff;
    logic                ge;
    logic                sat_pos;
    logic                sat_neg;

    always_comb begin
        shifted = {r_rem, r_num[PSUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
        sat_pos = !r_neg && (r_num > PSUM_W'(32767));
        sat_neg =  r_neg && (r_num > PSUM_W'(32768));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    // Take magnitudes; the quotient sign is the xor of the signs.
                    r_num  <= r_num[PSUM_W-1] ? -r_num : r_num;
                    r_den  <= r_den[WSUM_W-1] ? -r_den : r_den;
                    r_neg  <= r_num[PSUM_W-1] ^ r_den[WSUM_W-1];
                    r_zero <= (r_den == '0);
                    r_rem  <= '0;
                    r_cnt  <= CNT_W'(PSUM_W - 1);
                    r_state <= (r_den == '0) ? S_FINISH : S_RUN;
                end
                S_RUN: begin
                    r_rem   <= ge ? diff[WSUM_W-1:0] : shifted[WSUM_W-1:0];
                    r_num   <= {r_num[PSUM_W-2:0], ge};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    r_result.zero_weight_sum <= r_zero;
                    if (r_zero) begin
                        r_result.mean <= '0;
                    end else if (sat_pos) begin
                        r_result.mean <= 16'sh7fff;
                    end else if (sat_neg) begin
                        r_result.mean <= 16'sh8000;
                    end else begin
                        r_result.mean <= r_neg ? -r_num[WMU_DATA_W-1:0]
                                               :  r_num[WMU_DATA_W-1:0];
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
